[rtl/sic_pkg.sv]
package sic_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;
  localparam int NW = XW + DW;
  localparam int QW = DW;

  typedef enum logic [1:0] {
    OUT_NONE    = 2'd0,
    OUT_POINT   = 2'd1,
    OUT_OVERLAP = 2'd2,
    OUT_DEGEN   = 2'd3
  } outcome_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] p_start_x;
    logic signed [COORD_WIDTH-1:0] p_start_y;
    logic signed [COORD_WIDTH-1:0] p_end_x;
    logic signed [COORD_WIDTH-1:0] p_end_y;
    logic signed [COORD_WIDTH-1:0] q_start_x;
    logic signed [COORD_WIDTH-1:0] q_start_y;
    logic signed [COORD_WIDTH-1:0] q_end_x;
    logic signed [COORD_WIDTH-1:0] q_end_y;
    logic                          whole_lines;
  } seg_item_t;

  typedef struct packed {
    outcome_t                      outcome;
    logic signed [COORD_WIDTH-1:0] cross_x;
    logic signed [COORD_WIDTH-1:0] cross_y;
    logic                          point_clipped;
  } res_item_t;

  typedef struct packed {
    outcome_t                      code;
    logic signed [XW-1:0]          nt;
    logic [XW-1:0]                 den;
    logic signed [DW-1:0]          dpx;
    logic signed [DW-1:0]          dpy;
    logic signed [COORD_WIDTH-1:0] p1x;
    logic signed [COORD_WIDTH-1:0] p1y;
  } front_item_t;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [QW-1:0] q;
    logic          ov;
    logic          neg;
  } div_lane_t;

  typedef struct packed {
    outcome_t                      code;
    logic [XW-1:0]                 den;
    div_lane_t                     x;
    div_lane_t                     y;
    logic signed [COORD_WIDTH-1:0] p1x;
    logic signed [COORD_WIDTH-1:0] p1y;
  } div_item_t;

endpackage

[rtl/segment_intersection_core.sv]
// An accepted item passes in order through the cross-product front end, the scaling
// multiplier, the restoring divider and an output register. Throughput: one item per
// cycle unless stalled; each divider stage after the first retires one quotient bit.
// Every stage stalls on its own, so bubbles close up while a result waits.
// Reset: synchronous, active high; clears all valid bits and leaves data as it is.
module segment_intersection_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               seg_valid,
  output logic               seg_ready,
  input  sic_pkg::seg_item_t seg,
  output logic               res_valid,
  input  logic               res_ready,
  output sic_pkg::res_item_t res
);

  localparam int W  = sic_pkg::COORD_WIDTH;
  localparam int QW = sic_pkg::QW;

  logic                 f_valid, f_ready;
  sic_pkg::front_item_t f_item;
  logic                 m_valid, m_ready;
  sic_pkg::div_item_t   m_item;
  logic                 d_valid, d_ready;
  sic_pkg::div_item_t   d_item;
  sic_pkg::res_item_t   res_next;
  logic                 clip_x, clip_y;
  logic signed [W-1:0]  cx, cy;

  sic_front u_front (
    .clk(clk), .rst(rst),
    .up_valid(seg_valid), .up_ready(seg_ready), .up_item(seg),
    .dn_valid(f_valid), .dn_ready(f_ready), .dn_item(f_item)
  );

  sic_scale u_scale (
    .clk(clk), .rst(rst),
    .up_valid(f_valid), .up_ready(f_ready), .up_item(f_item),
    .dn_valid(m_valid), .dn_ready(m_ready), .dn_item(m_item)
  );

  sic_divider u_divider (
    .clk(clk), .rst(rst),
    .up_valid(m_valid), .up_ready(m_ready), .up_item(m_item),
    .dn_valid(d_valid), .dn_ready(d_ready), .dn_item(d_item)
  );

  function automatic logic [W:0] place(input logic signed [W-1:0] base,
                                       input sic_pkg::div_lane_t l);
    logic [QW:0]  q;
    logic [W+2:0] b;
    logic [W+2:0] sum;
    logic [W:0]   r;
    q   = l.ov ? {1'b1, {QW{1'b0}}} : {1'b0, l.q};
    b   = {{3{base[W-1]}}, base};
    sum = l.neg ? b - (W+3)'(q) : b + (W+3)'(q);
    if (sum[W+2:W-1] == '0 || sum[W+2:W-1] == '1) begin
      r = {1'b0, sum[W-1:0]};
    end else if (sum[W+2]) begin
      r = {1'b1, 1'b1, {(W-1){1'b0}}};
    end else begin
      r = {1'b1, 1'b0, {(W-1){1'b1}}};
    end
    return r;
  endfunction

  assign {clip_x, cx} = place(d_item.p1x, d_item.x);
  assign {clip_y, cy} = place(d_item.p1y, d_item.y);

  always_comb begin
    res_next.outcome = d_item.code;
    if (d_item.code == sic_pkg::OUT_POINT) begin
      res_next.cross_x       = cx;
      res_next.cross_y       = cy;
      res_next.point_clipped = clip_x || clip_y;
    end else begin
      res_next.cross_x       = '0;
      res_next.cross_y       = '0;
      res_next.point_clipped = 1'b0;
    end
  end

  assign d_ready = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (d_ready) begin
      res_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) res <= res_next;
  end

`ifndef SYNTHESIS
  a_no_point_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.outcome != sic_pkg::OUT_POINT
      |-> res.cross_x == '0 && res.cross_y == '0 && !res.point_clipped)
    else $error("result without a point carries a non-zero point");

  a_clip_at_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.point_clipped
      |-> res.cross_x == {1'b1, {(W-1){1'b0}}} || res.cross_x == {1'b0, {(W-1){1'b1}}}
       || res.cross_y == {1'b1, {(W-1){1'b0}}} || res.cross_y == {1'b0, {(W-1){1'b1}}})
    else $error("clipped point has no coordinate at a bound");

  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");
`endif

endmodule

[rtl/sic_front.sv]
module sic_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  sic_pkg::seg_item_t   up_item,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output sic_pkg::front_item_t dn_item
);

  localparam int W  = sic_pkg::COORD_WIDTH;
  localparam int DW = sic_pkg::DW;
  localparam int PW = sic_pkg::PW;
  localparam int XW = sic_pkg::XW;

  typedef struct packed {
    logic signed [DW-1:0] dpx, dpy, dqx, dqy, wx, wy, vx, vy, ex, ey;
    logic signed [W-1:0]  p1x, p1y;
    logic                 degen;
    logic                 whole;
  } diff_t;

  typedef struct packed {
    logic signed [PW-1:0] dpx_dqy, dpy_dqx, wx_dqy, wy_dqx, wx_dpy, wy_dpx;
    logic signed [PW-1:0] wx_dpx, wy_dpy, vx_dpx, vy_dpy, dpx2, dpy2, dqx2, dqy2;
    logic signed [PW-1:0] wx_dqx, wy_dqy, ex_dqx, ey_dqy;
    logic signed [DW-1:0] dpx, dpy;
    logic signed [W-1:0]  p1x, p1y;
    logic                 degen;
    logic                 whole;
  } prod_t;

  typedef struct packed {
    logic signed [XW-1:0] den, nt, ns, lp, lq, d1, d2, d3, d4;
    logic signed [DW-1:0] dpx, dpy;
    logic signed [W-1:0]  p1x, p1y;
    logic                 degen;
    logic                 whole;
  } sum_t;

  logic [3:0]           v;
  logic [3:0]           rdy;
  diff_t                s0, s0_next;
  prod_t                s1, s1_next;
  sum_t                 s2, s2_next;
  sic_pkg::front_item_t s3, s3_next;

  function automatic logic in_range(input logic signed [XW-1:0] a,
                                    input logic signed [XW-1:0] len);
    return !a[XW-1] && (a <= len);
  endfunction

  assign rdy[3]   = !v[3] || dn_ready;
  assign rdy[2]   = !v[2] || rdy[3];
  assign rdy[1]   = !v[1] || rdy[2];
  assign rdy[0]   = !v[0] || rdy[1];
  assign up_ready = rdy[0];
  assign dn_valid = v[3];
  assign dn_item  = s3;

  always_comb begin
    s0_next.dpx   = {up_item.p_end_x[W-1], up_item.p_end_x}
                  - {up_item.p_start_x[W-1], up_item.p_start_x};
    s0_next.dpy   = {up_item.p_end_y[W-1], up_item.p_end_y}
                  - {up_item.p_start_y[W-1], up_item.p_start_y};
    s0_next.dqx   = {up_item.q_end_x[W-1], up_item.q_end_x}
                  - {up_item.q_start_x[W-1], up_item.q_start_x};
    s0_next.dqy   = {up_item.q_end_y[W-1], up_item.q_end_y}
                  - {up_item.q_start_y[W-1], up_item.q_start_y};
    s0_next.wx    = {up_item.q_start_x[W-1], up_item.q_start_x}
                  - {up_item.p_start_x[W-1], up_item.p_start_x};
    s0_next.wy    = {up_item.q_start_y[W-1], up_item.q_start_y}
                  - {up_item.p_start_y[W-1], up_item.p_start_y};
    s0_next.vx    = {up_item.q_end_x[W-1], up_item.q_end_x}
                  - {up_item.p_start_x[W-1], up_item.p_start_x};
    s0_next.vy    = {up_item.q_end_y[W-1], up_item.q_end_y}
                  - {up_item.p_start_y[W-1], up_item.p_start_y};
    s0_next.ex    = {up_item.p_end_x[W-1], up_item.p_end_x}
                  - {up_item.q_start_x[W-1], up_item.q_start_x};
    s0_next.ey    = {up_item.p_end_y[W-1], up_item.p_end_y}
                  - {up_item.q_start_y[W-1], up_item.q_start_y};
    s0_next.p1x   = up_item.p_start_x;
    s0_next.p1y   = up_item.p_start_y;
    s0_next.whole = up_item.whole_lines;
    s0_next.degen = ((s0_next.dpx == '0) && (s0_next.dpy == '0))
                 || ((s0_next.dqx == '0) && (s0_next.dqy == '0));
  end

  always_comb begin
    s1_next.dpx_dqy = s0.dpx * s0.dqy;
    s1_next.dpy_dqx = s0.dpy * s0.dqx;
    s1_next.wx_dqy  = s0.wx * s0.dqy;
    s1_next.wy_dqx  = s0.wy * s0.dqx;
    s1_next.wx_dpy  = s0.wx * s0.dpy;
    s1_next.wy_dpx  = s0.wy * s0.dpx;
    s1_next.wx_dpx  = s0.wx * s0.dpx;
    s1_next.wy_dpy  = s0.wy * s0.dpy;
    s1_next.vx_dpx  = s0.vx * s0.dpx;
    s1_next.vy_dpy  = s0.vy * s0.dpy;
    s1_next.dpx2    = s0.dpx * s0.dpx;
    s1_next.dpy2    = s0.dpy * s0.dpy;
    s1_next.dqx2    = s0.dqx * s0.dqx;
    s1_next.dqy2    = s0.dqy * s0.dqy;
    s1_next.wx_dqx  = s0.wx * s0.dqx;
    s1_next.wy_dqy  = s0.wy * s0.dqy;
    s1_next.ex_dqx  = s0.ex * s0.dqx;
    s1_next.ey_dqy  = s0.ey * s0.dqy;
    s1_next.dpx     = s0.dpx;
    s1_next.dpy     = s0.dpy;
    s1_next.p1x     = s0.p1x;
    s1_next.p1y     = s0.p1y;
    s1_next.degen   = s0.degen;
    s1_next.whole   = s0.whole;
  end

  always_comb begin
    s2_next.den   = XW'(s1.dpx_dqy) - XW'(s1.dpy_dqx);
    s2_next.nt    = XW'(s1.wx_dqy) - XW'(s1.wy_dqx);
    s2_next.ns    = XW'(s1.wx_dpy) - XW'(s1.wy_dpx);
    s2_next.lp    = XW'(s1.dpx2) + XW'(s1.dpy2);
    s2_next.lq    = XW'(s1.dqx2) + XW'(s1.dqy2);
    s2_next.d1    = XW'(s1.wx_dpx) + XW'(s1.wy_dpy);
    s2_next.d2    = XW'(s1.vx_dpx) + XW'(s1.vy_dpy);
    s2_next.d3    = -XW'(s1.wx_dqx) - XW'(s1.wy_dqy);
    s2_next.d4    = XW'(s1.ex_dqx) + XW'(s1.ey_dqy);
    s2_next.dpx   = s1.dpx;
    s2_next.dpy   = s1.dpy;
    s2_next.p1x   = s1.p1x;
    s2_next.p1y   = s1.p1y;
    s2_next.degen = s1.degen;
    s2_next.whole = s1.whole;
  end

  always_comb begin
    logic signed [XW-1:0] den_n;
    logic signed [XW-1:0] nt_n;
    logic signed [XW-1:0] ns_n;
    logic                 overlap;
    den_n   = s2.den[XW-1] ? -s2.den : s2.den;
    nt_n    = s2.den[XW-1] ? -s2.nt : s2.nt;
    ns_n    = s2.den[XW-1] ? -s2.ns : s2.ns;
    overlap = in_range(s2.d1, s2.lp) || in_range(s2.d2, s2.lp)
           || in_range(s2.d3, s2.lq) || in_range(s2.d4, s2.lq);
    if (s2.degen) begin
      s3_next.code = sic_pkg::OUT_DEGEN;
    end else if (s2.den == '0) begin
      if (s2.nt != '0) begin
        s3_next.code = sic_pkg::OUT_NONE;
      end else if (s2.whole || overlap) begin
        s3_next.code = sic_pkg::OUT_OVERLAP;
      end else begin
        s3_next.code = sic_pkg::OUT_NONE;
      end
    end else if (!s2.whole && !(in_range(nt_n, den_n) && in_range(ns_n, den_n))) begin
      s3_next.code = sic_pkg::OUT_NONE;
    end else begin
      s3_next.code = sic_pkg::OUT_POINT;
    end
    s3_next.nt  = nt_n;
    s3_next.den = den_n;
    s3_next.dpx = s2.dpx;
    s3_next.dpy = s2.dpy;
    s3_next.p1x = s2.p1x;
    s3_next.p1y = s2.p1y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= up_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) s0 <= s0_next;
    if (rdy[1]) s1 <= s1_next;
    if (rdy[2]) s2 <= s2_next;
    if (rdy[3]) s3 <= s3_next;
  end

endmodule

[rtl/sic_scale.sv]
module sic_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  sic_pkg::front_item_t up_item,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output sic_pkg::div_item_t   dn_item
);

  localparam int DW = sic_pkg::DW;
  localparam int XW = sic_pkg::XW;

  logic               v;
  sic_pkg::div_item_t s, s_next;

  assign up_ready = !v || dn_ready;
  assign dn_valid = v;
  assign dn_item  = s;

  always_comb begin
    logic [XW-1:0] nt_mag;
    logic [DW-1:0] dx_mag;
    logic [DW-1:0] dy_mag;
    nt_mag   = up_item.nt[XW-1] ? XW'(-up_item.nt) : XW'(up_item.nt);
    dx_mag   = up_item.dpx[DW-1] ? DW'(-up_item.dpx) : DW'(up_item.dpx);
    dy_mag   = up_item.dpy[DW-1] ? DW'(-up_item.dpy) : DW'(up_item.dpy);
    s_next.code  = up_item.code;
    s_next.den   = up_item.den;
    s_next.x.rem = nt_mag * dx_mag;
    s_next.x.q   = '0;
    s_next.x.ov  = 1'b0;
    s_next.x.neg = up_item.nt[XW-1] ^ up_item.dpx[DW-1];
    s_next.y.rem = nt_mag * dy_mag;
    s_next.y.q   = '0;
    s_next.y.ov  = 1'b0;
    s_next.y.neg = up_item.nt[XW-1] ^ up_item.dpy[DW-1];
    s_next.p1x   = up_item.p1x;
    s_next.p1y   = up_item.p1y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (up_ready) begin
      v <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) s <= s_next;
  end

endmodule

[rtl/sic_divider.sv]
module sic_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  sic_pkg::div_item_t up_item,
  output logic               dn_valid,
  input  logic               dn_ready,
  output sic_pkg::div_item_t dn_item
);

  localparam int NW = sic_pkg::NW;
  localparam int QW = sic_pkg::QW;

  logic [QW:0]        v;
  logic [QW+1:0]      rdy;
  sic_pkg::div_item_t stage_q [QW+1];
  sic_pkg::div_item_t stage_next [QW+1];

  function automatic sic_pkg::div_lane_t lane_step(input sic_pkg::div_lane_t l,
                                                   input logic [NW-1:0] d,
                                                   input int bit_pos);
    sic_pkg::div_lane_t r;
    r = l;
    if (l.rem >= d) begin
      r.rem        = l.rem - d;
      r.q[bit_pos] = 1'b1;
    end
    return r;
  endfunction

  assign rdy[QW+1] = dn_ready;
  assign up_ready  = rdy[0];
  assign dn_valid  = v[QW];
  assign dn_item   = stage_q[QW];

  for (genvar s = 0; s <= QW; s++) begin : g_stage
    assign rdy[s] = !v[s] || rdy[s+1];

    if (s == 0) begin : g_first
      always_comb begin
        logic [NW-1:0] lim;
        lim           = NW'(up_item.den) << QW;
        stage_next[s] = up_item;
        stage_next[s].x.ov = up_item.x.rem >= lim;
        stage_next[s].y.ov = up_item.y.rem >= lim;
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[s] <= 1'b0;
        end else if (rdy[s]) begin
          v[s] <= up_valid;
        end
      end
    end else begin : g_bit
      always_comb begin
        logic [NW-1:0] d;
        d             = NW'(stage_q[s-1].den) << (QW - s);
        stage_next[s] = stage_q[s-1];
        stage_next[s].x = lane_step(stage_q[s-1].x, d, QW - s);
        stage_next[s].y = lane_step(stage_q[s-1].y, d, QW - s);
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[s] <= 1'b0;
        end else if (rdy[s]) begin
          v[s] <= v[s-1];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) stage_q[s] <= stage_next[s];
    end
  end

endmodule
